@@ hdl/ecbf_pkg.sv @@
// Shared constants and divider handshake types for the clipped box filter.
// No dependencies; ecbf_div and the top level refer to it by scoped names.
package ecbf_pkg;

  localparam int PIX_W   = 16;  // raw pixel sample
  localparam int CRD_W   = 8;   // col / row coordinate
  localparam int DIM_W   = 9;   // frame_width / frame_height register
  localparam int WS_W    = 4;   // window_size register
  localparam int HALF_W  = 3;   // half-width, at most 7
  localparam int SPAN_W  = 4;   // clipped window span, at most 15
  localparam int CNT_W   = 8;   // covered pixel count, at most 225
  localparam int SUM_W   = 24;  // window sum, at most 225 * 65535
  localparam int FRAC_W  = 8;   // fraction bits of the mean
  localparam int NUM_W   = SUM_W + FRAC_W;  // dividend of the mean
  localparam int OUT_W   = 24;  // filtered_value
  localparam int CIDX_W  = 2;   // configuration register index
  localparam int CDAT_W  = 9;   // configuration write data

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int DEF_MAX_WINDOW = 15;

  localparam logic [WS_W-1:0]  RST_WINDOW_SIZE  = 4'd3;
  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 9'd256;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 9'd256;

  localparam logic [CIDX_W-1:0] REG_WINDOW_SIZE  = 2'd0;
  localparam logic [CIDX_W-1:0] REG_FRAME_WIDTH  = 2'd1;
  localparam logic [CIDX_W-1:0] REG_FRAME_HEIGHT = 2'd2;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [OUT_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ hdl/ecbf_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module ecbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/ecbf_div.sv @@
// Restoring divider, one quotient bit per cycle, for the rounded window mean.
// Depends on ecbf_pkg for widths and the request / response structs.
module ecbf_div (
  input  logic              clk,
  input  logic              rst,
  input  ecbf_pkg::div_req_t req,
  output ecbf_pkg::div_rsp_t rsp
);

  localparam int STEP_W = $clog2(ecbf_pkg::NUM_W);

  logic [ecbf_pkg::NUM_W-1:0] dvd;
  logic [ecbf_pkg::CNT_W-1:0] rem;
  logic [ecbf_pkg::CNT_W-1:0] dsr;
  logic [STEP_W-1:0]          step;
  logic                       busy;
  logic                       done;

  logic [ecbf_pkg::CNT_W:0]   rem_sh;
  logic                       ge;
  logic [ecbf_pkg::CNT_W-1:0] rem_next;
  logic [ecbf_pkg::NUM_W-1:0] dvd_next;

  always_comb begin
    rem_sh   = {rem, dvd[ecbf_pkg::NUM_W-1]};
    ge       = (rem_sh >= {1'b0, dsr});
    rem_next = ge ? ecbf_pkg::CNT_W'(rem_sh - {1'b0, dsr}) : rem_sh[ecbf_pkg::CNT_W-1:0];
    dvd_next = {dvd[ecbf_pkg::NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= STEP_W'(ecbf_pkg::NUM_W - 1);
    end else if (busy) begin
      // advance one bit; stop after the last one
      step <= step - 1'b1;
      if (step == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd <= req.dividend;
      rem <= '0;
      dsr <= req.divisor;
    end else if (busy) begin
      dvd <= dvd_next;
      rem <= rem_next;
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = dvd[ecbf_pkg::OUT_W-1:0];

endmodule

@@ hdl/edge_clipped_box_filter_2d.sv @@
// Top level of the clipped 2-D box mean filter: frame store, window walk, mean.
// Depends on ecbf_pkg, ecbf_ram (frame store) and ecbf_div (serial divider).
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  input   | in_valid, in_ready, op, col, row, pixel_value  | in
//  result  | out_valid, out_ready, filtered_value           | out
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data      | in
//
// A store is written from idle. A read runs in order: acceptance in idle, setup,
// one frame-store read per covered pixel (at most 225) through the single RAM
// read port, a drain step, the divider load, the divider steps, the divider's
// done flag and the hand-off to the output register. A read outside the frame
// goes from setup straight to the hand-off.
// Reset (rst, synchronous) loads the register defaults and idles the block;
// the frame store holds whatever it held and must be loaded before reads.
// A result waiting on out_ready does not block stores; a second read waits
// for the output register to free before it finishes.
module edge_clipped_box_filter_2d #(
  parameter int MAX_WIDTH  = ecbf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = ecbf_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_WINDOW = ecbf_pkg::DEF_MAX_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [ecbf_pkg::CRD_W-1:0]  col,
  input  logic [ecbf_pkg::CRD_W-1:0]  row,
  input  logic [ecbf_pkg::PIX_W-1:0]  pixel_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [ecbf_pkg::OUT_W-1:0]  filtered_value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ecbf_pkg::CIDX_W-1:0] cfg_index,
  input  logic [ecbf_pkg::CDAT_W-1:0] cfg_data
);

  // Address split of the frame store: row bits above column bits.
  localparam int XW     = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int AW     = XW + YW;
  localparam int DEPTH  = 2 ** AW;
  localparam int DW     = ecbf_pkg::DIM_W;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_SETUP  = 6'b000010,
    S_WALK   = 6'b000100,
    S_DRAIN  = 6'b001000,
    S_DIV    = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t state, state_next;

  // configuration registers
  logic [ecbf_pkg::WS_W-1:0] window_size;
  logic [DW-1:0]             frame_width;
  logic [DW-1:0]             frame_height;

  // effective frame size and half-width
  logic [DW-1:0]               w_eff, h_eff;
  logic [ecbf_pkg::WS_W-1:0]   ws_eff;
  logic [ecbf_pkg::HALF_W-1:0] half;
  logic                        in_frame;

  // read command and window bounds
  logic [ecbf_pkg::CRD_W-1:0] c_cmd, r_cmd;
  logic                       zero_res;
  logic [DW-1:0]              x1, x2, y2;
  logic [DW-1:0]              x1_next, x2_next, y1_next, y2_next;
  logic [DW-1:0]              cx_hi, ry_hi;
  logic [ecbf_pkg::CNT_W-1:0] cnt, cnt_next;
  logic [DW-1:0]              x, y;
  logic                       rd_pend;
  logic [ecbf_pkg::SUM_W-1:0] sum;
  logic                       div_go;

  // frame store
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr, ram_raddr;
  logic [ecbf_pkg::PIX_W-1:0] ram_rdata;

  ecbf_pkg::div_req_t div_req;
  ecbf_pkg::div_rsp_t div_rsp;

  logic in_xfer, out_free;

  // --------------------------------------------------------------------------
  // Configuration: always ready; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= ecbf_pkg::RST_WINDOW_SIZE;
      frame_width  <= ecbf_pkg::RST_FRAME_WIDTH;
      frame_height <= ecbf_pkg::RST_FRAME_HEIGHT;
    end else if (cfg_valid) begin
      case (cfg_index)
        ecbf_pkg::REG_WINDOW_SIZE:  window_size  <= cfg_data[ecbf_pkg::WS_W-1:0];
        ecbf_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        ecbf_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Zero size acts as one, oversize clamps to the store's dimension; window size clamps to MAX_WINDOW.
  always_comb begin
    if (frame_width == '0) begin
      w_eff = DW'(1);
    end else if (32'(frame_width) > MAX_WIDTH) begin
      w_eff = DW'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height == '0) begin
      h_eff = DW'(1);
    end else if (32'(frame_height) > MAX_HEIGHT) begin
      h_eff = DW'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    if (32'(window_size) > MAX_WINDOW) begin
      ws_eff = ecbf_pkg::WS_W'(MAX_WINDOW);
    end else begin
      ws_eff = window_size;
    end
    half = ws_eff[ecbf_pkg::WS_W-1:1];
  end

  // --------------------------------------------------------------------------
  // Input side: a store writes straight into the frame store from idle.
  assign in_ready = (state == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign in_frame = ({1'b0, col} < w_eff) && ({1'b0, row} < h_eff);

  assign ram_we    = in_xfer && (op == ecbf_pkg::OP_STORE) && in_frame;
  assign ram_waddr = {YW'(row), XW'(col)};
  assign ram_raddr = {YW'(y), XW'(x)};

  ecbf_ram #(
    .WIDTH (ecbf_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (pixel_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Window bounds, clipped at the frame edges.
  always_comb begin
    cx_hi   = DW'(c_cmd) + DW'(half);
    ry_hi   = DW'(r_cmd) + DW'(half);
    x1_next = (c_cmd > ecbf_pkg::CRD_W'(half)) ? DW'(c_cmd) - DW'(half) : '0;
    y1_next = (r_cmd > ecbf_pkg::CRD_W'(half)) ? DW'(r_cmd) - DW'(half) : '0;
    x2_next = (cx_hi > w_eff - 1'b1) ? w_eff - 1'b1 : cx_hi;
    y2_next = (ry_hi > h_eff - 1'b1) ? h_eff - 1'b1 : ry_hi;
    cnt_next = ecbf_pkg::SPAN_W'(x2_next - x1_next + 1'b1)
             * ecbf_pkg::SPAN_W'(y2_next - y1_next + 1'b1);
  end

  // --------------------------------------------------------------------------
  // Sequencer
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer && (op == ecbf_pkg::OP_READ)) begin
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        state_next = zero_res ? S_FINISH : S_WALK;
      end
      S_WALK: begin
        if ((x == x2) && (y == y2)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!div_go && div_rsp.done) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      div_go  <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_WALK);
      div_go  <= (state == S_DRAIN);
    end
  end

  // Command capture, bounds and window walk.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      c_cmd    <= col;
      r_cmd    <= row;
      zero_res <= !in_frame;
    end
    if (state == S_SETUP) begin
      x1  <= x1_next;
      x2  <= x2_next;
      y2  <= y2_next;
      cnt <= cnt_next;
      x   <= x1_next;
      y   <= y1_next;
      sum <= '0;
    end else begin
      if (state == S_WALK) begin
        // advance along the row, then wrap to the next row
        if (x == x2) begin
          x <= x1;
          y <= y + 1'b1;
        end else begin
          x <= x + 1'b1;
        end
      end
      if (rd_pend) begin
        sum <= sum + ecbf_pkg::SUM_W'(ram_rdata);
      end
    end
  end

  // Rounded mean: (sum * 256 + cnt / 2) / cnt.
  assign div_req.start    = div_go;
  assign div_req.dividend = {sum, {ecbf_pkg::FRAC_W{1'b0}}}
                          + ecbf_pkg::NUM_W'(cnt >> 1);
  assign div_req.divisor  = cnt;

  ecbf_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // --------------------------------------------------------------------------
  // Output register: load on finish, hold until the transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FINISH) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FINISH) && out_free) begin
      filtered_value <= zero_res ? '0 : div_rsp.quotient;
    end
  end

`ifndef SYNTHESIS
  // Every walk cycle issues a frame-store read that is summed next cycle.
  a_walk_reads: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |=> rd_pend)
    else $error("walk cycle without a pending read");

  // The divisor of a walked window is never zero.
  a_cnt_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_DRAIN || state == S_DIV) |-> (cnt != '0))
    else $error("zero pixel count in window");

  // A free output register ends a read and returns the block to idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_FINISH && out_free) |=> (out_valid && state == S_IDLE))
    else $error("finished read did not reach the output");

  // The divider is started only after the window sum is complete.
  a_div_after_sum: assert property (@(posedge clk) disable iff (rst)
    div_go |-> (!rd_pend && $past(state) == S_DRAIN))
    else $error("divider started with reads in flight");
`endif

endmodule
